FILE: rtl/core/stream_literal_substitution_unit_assert.svh
// Assertion macros used by the stream literal substitution unit top level.
`ifndef STREAM_LITERAL_SUBSTITUTION_UNIT_ASSERT_SVH
`define STREAM_LITERAL_SUBSTITUTION_UNIT_ASSERT_SVH

`ifndef SYNTH

// The consequent must hold in the same cycle as the antecedent.
`define SLSU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slsu assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slsu assertion failed");

`else

`define SLSU_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: rtl/core/slsu_pkg.sv
// Shared types and constants of the stream literal substitution unit.
package slsu_pkg;

    localparam int MAX_PATTERN     = 8;
    localparam int MAX_REPLACEMENT = 8;
    localparam int BYTE_W          = 8;
    localparam int LEN_W           = 4;
    localparam int CNT_W           = $clog2(MAX_PATTERN + 1);
    localparam int IDX_W           = $clog2(MAX_PATTERN);
    localparam int RLEN_W          = $clog2(MAX_REPLACEMENT + 1);
    localparam int RIDX_W          = $clog2(MAX_REPLACEMENT);
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 64;

    typedef logic [BYTE_W-1:0] byte_t;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1,
        CFG_REPL_BYTES     = 2'd2,
        CFG_REPL_LENGTH    = 2'd3
    } cfg_index_t;

    // Configuration as seen by the datapath, lengths already clamped.
    typedef struct packed {
        logic [MAX_PATTERN*BYTE_W-1:0]     pattern;
        logic [CNT_W-1:0]                  plen;
        logic [MAX_REPLACEMENT*BYTE_W-1:0] repl;
        logic [RLEN_W-1:0]                 rlen;
    } cfg_t;

    // Result of the prefix compare unit.
    typedef struct packed {
        logic is_prefix;
        logic is_match;
    } cmp_t;

endpackage

FILE: rtl/core/stream_literal_substitution_unit.sv
// Top level of the stream literal substitution unit: sequencer, buffer, output stage.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------
//  in      | input     | in_valid/in_stall  | in_byte, in_last
//  out     | output    | out_valid/out_stall| out_byte, has_byte, out_last, not_found
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A word is taken in and checked against the pattern; then each emitted byte (dropped
// candidate, replacement or flushed byte) goes out in turn, a closing step follows, and
// a flush at end of stream ends with one more step, all set by the sequencer that runs
// the one prefix compare unit.
// Emitted bytes pass through a one-word holding stage, so the byte ending a stream can be
// marked last; out_stall pauses the sequencer while it is full and in the closing step.
// Reset clears the candidate count, match flag and all control; in_stall is low when idle.
module stream_literal_substitution_unit
    import slsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [BYTE_W-1:0]     in_byte,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [BYTE_W-1:0]     out_byte,
    output logic                  has_byte,
    output logic                  out_last,
    output logic                  not_found,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "stream_literal_substitution_unit_assert.svh"

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_REPL,
        ST_FLUSH,
        ST_FINISH
    } state_t;

    cfg_t              cfg;
    cmp_t              cmp;
    state_t            state_reg,      state_next;
    byte_t             cand_reg  [MAX_PATTERN];
    byte_t             cand_next [MAX_PATTERN];
    logic [CNT_W-1:0]  count_reg,      count_next;
    logic              match_reg,      match_next;
    logic              last_reg,       last_next;
    logic [RIDX_W-1:0] ridx_reg,       ridx_next;
    logic              pend_valid_reg, pend_valid_next;
    byte_t             pend_byte_reg,  pend_byte_next;
    logic              out_valid_reg,  out_valid_next;
    byte_t             out_byte_reg,   out_byte_next;
    logic              has_byte_reg,   has_byte_next;
    logic              out_last_reg,   out_last_next;
    logic              not_found_reg,  not_found_next;
    logic              out_free;
    logic              can_emit;
    logic              emit_en;
    byte_t             emit_byte;

    slsu_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slsu_prefix_cmp u_cmp (
        .cand    (cand_reg),
        .count   (count_reg),
        .pattern (cfg.pattern),
        .plen    (cfg.plen),
        .result  (cmp)
    );

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign has_byte  = has_byte_reg;
    assign out_last  = out_last_reg;
    assign not_found = not_found_reg;

    // The output register frees up when empty or when its word is taken.
    assign out_free = !out_valid_reg || !out_stall;
    assign can_emit = !pend_valid_reg || out_free;

    // Sequencer next-state and datapath control.
    always_comb
    begin
        state_next      = state_reg;
        cand_next       = cand_reg;
        count_next      = count_reg;
        match_next      = match_reg;
        last_next       = last_reg;
        ridx_next       = ridx_reg;
        pend_valid_next = pend_valid_reg;
        pend_byte_next  = pend_byte_reg;
        out_valid_next  = out_valid_reg;
        out_byte_next   = out_byte_reg;
        has_byte_next   = has_byte_reg;
        out_last_next   = out_last_reg;
        not_found_next  = not_found_reg;
        emit_en         = 1'b0;
        emit_byte       = cand_reg[0];

        if (out_free)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cand_next[count_reg[IDX_W-1:0]] = in_byte;
                    count_next = count_reg + CNT_W'(1);
                    last_next  = in_last;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (!cmp.is_prefix)
                begin
                    // Oldest byte can no longer start a match: pass it on.
                    if (can_emit)
                    begin
                        emit_en   = 1'b1;
                        emit_byte = cand_reg[0];
                        for (int i = 0; i < MAX_PATTERN - 1; i++)
                            cand_next[i] = cand_reg[i+1];
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                else if (cmp.is_match)
                begin
                    count_next = '0;
                    match_next = 1'b1;
                    ridx_next  = '0;
                    state_next = (cfg.rlen != '0) ? ST_REPL : ST_FINISH;
                end
                else
                begin
                    state_next = last_reg ? ST_FLUSH : ST_FINISH;
                end
            end
            ST_REPL:
            begin
                if (can_emit)
                begin
                    emit_en   = 1'b1;
                    emit_byte = cfg.repl[ridx_reg*BYTE_W +: BYTE_W];
                    ridx_next = ridx_reg + RIDX_W'(1);
                    if ((RLEN_W'(ridx_reg) + RLEN_W'(1)) == cfg.rlen)
                        state_next = ST_FINISH;
                end
            end
            ST_FLUSH:
            begin
                // End of stream: the remaining candidate goes out unchanged.
                if (count_reg == '0)
                    state_next = ST_FINISH;
                else if (can_emit)
                begin
                    emit_en   = 1'b1;
                    emit_byte = cand_reg[0];
                    for (int i = 0; i < MAX_PATTERN - 1; i++)
                        cand_next[i] = cand_reg[i+1];
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_FINISH:
            begin
                // Release the held word, marked as final at end of stream, or else a bare end marker.
                if (pend_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        out_byte_next   = pend_byte_reg;
                        has_byte_next   = 1'b1;
                        out_last_next   = last_reg;
                        not_found_next  = last_reg && !match_reg;
                        pend_valid_next = 1'b0;
                        state_next      = ST_IDLE;
                        if (last_reg)
                            match_next = 1'b0;
                    end
                end
                else if (last_reg)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = '0;
                        has_byte_next  = 1'b0;
                        out_last_next  = 1'b1;
                        not_found_next = !match_reg;
                        match_next     = 1'b0;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // A new byte pushes the held one into the output register.
        if (emit_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_byte_next  = pend_byte_reg;
                has_byte_next  = 1'b1;
                out_last_next  = 1'b0;
                not_found_next = 1'b0;
            end
            pend_byte_next  = emit_byte;
            pend_valid_next = 1'b1;
        end
    end

    // State, control and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            match_reg      <= 1'b0;
            last_reg       <= 1'b0;
            ridx_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_byte_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            has_byte_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
            not_found_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            match_reg      <= match_next;
            last_reg       <= last_next;
            ridx_reg       <= ridx_next;
            pend_valid_reg <= pend_valid_next;
            pend_byte_reg  <= pend_byte_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            has_byte_reg   <= has_byte_next;
            out_last_reg   <= out_last_next;
            not_found_reg  <= not_found_next;
        end
    end

    // Candidate buffer contents need no reset: only entries below the count are read.
    always_ff @(posedge clk)
    begin
        cand_reg <= cand_next;
    end

    // Nothing may be held back while the block waits for a new word.
    `SLSU_ASSERT_SAME(a_idle_no_pending, clk, rst_n,
        state_reg == ST_IDLE, !pend_valid_reg)
    // The replacement is only sent after a match emptied the buffer.
    `SLSU_ASSERT_SAME(a_repl_empty_buf, clk, rst_n,
        state_reg == ST_REPL, count_reg == '0 && match_reg)
    // The buffer never holds more than a full pattern.
    `SLSU_ASSERT_SAME(a_count_bound, clk, rst_n,
        1'b1, count_reg <= CNT_W'(MAX_PATTERN))
    // A bare end marker is only ever the final word of a stream.
    `SLSU_ASSERT_SAME(a_marker_is_last, clk, rst_n,
        out_valid_reg && !has_byte_reg, out_last_reg && out_byte_reg == '0)
    // A final word ends the stream's match history.
    `SLSU_ASSERT_NEXT(a_last_clears_match, clk, rst_n,
        state_reg == ST_FINISH && last_reg && state_next == ST_IDLE,
        !match_reg && count_reg == '0)

endmodule

FILE: rtl/core/slsu_cfg_regs.sv
// Configuration registers and clamped pattern and replacement lengths.
module slsu_cfg_regs
    import slsu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [CFG_DATA_W-1:0] pattern_reg;
    logic [LEN_W-1:0]      plen_raw_reg;
    logic [CFG_DATA_W-1:0] repl_reg;
    logic [LEN_W-1:0]      rlen_raw_reg;

    // The user must make writes only while the block is idle; the block does not enforce it, so the port never waits.
    assign cfg_ready = 1'b1;

    // Register file write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg  <= '0;
            plen_raw_reg <= LEN_W'(1);
            repl_reg     <= '0;
            rlen_raw_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PATTERN_BYTES:  pattern_reg  <= cfg_data;
                CFG_PATTERN_LENGTH: plen_raw_reg <= cfg_data[LEN_W-1:0];
                CFG_REPL_BYTES:     repl_reg     <= cfg_data;
                CFG_REPL_LENGTH:    rlen_raw_reg <= cfg_data[LEN_W-1:0];
                default:            ;
            endcase
        end
    end

    // An empty pattern counts as one byte; over-long lengths saturate.
    always_comb
    begin
        cfg.pattern = pattern_reg[MAX_PATTERN*BYTE_W-1:0];
        cfg.repl    = repl_reg[MAX_REPLACEMENT*BYTE_W-1:0];
        if (plen_raw_reg == '0)
            cfg.plen = CNT_W'(1);
        else if (plen_raw_reg > LEN_W'(MAX_PATTERN))
            cfg.plen = CNT_W'(MAX_PATTERN);
        else
            cfg.plen = CNT_W'(plen_raw_reg);
        if (rlen_raw_reg > LEN_W'(MAX_REPLACEMENT))
            cfg.rlen = RLEN_W'(MAX_REPLACEMENT);
        else
            cfg.rlen = RLEN_W'(rlen_raw_reg);
    end

endmodule

FILE: rtl/core/slsu_prefix_cmp.sv
// Shared compare unit: is the candidate buffer a prefix, or all, of the pattern.
module slsu_prefix_cmp
    import slsu_pkg::*;
(
    input  byte_t                         cand [MAX_PATTERN],
    input  logic [CNT_W-1:0]              count,
    input  logic [MAX_PATTERN*BYTE_W-1:0] pattern,
    input  logic [CNT_W-1:0]              plen,
    output cmp_t                          result
);

    logic [MAX_PATTERN-1:0] lane_ok;

    // Each lane compares one buffered byte; lanes past the count always agree.
    always_comb
    begin
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            lane_ok[i] = (CNT_W'(i) >= count) ||
                         (cand[i] == pattern[i*BYTE_W +: BYTE_W]);
        end
        result.is_prefix = (count <= plen) && (&lane_ok);
        result.is_match  = result.is_prefix && (count == plen);
    end

endmodule
